### design/bgf_pkg.sv
// shared types and constants of the bit-granular fifo
`default_nettype none

package bgf_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LEN_W         = 6;
    localparam int unsigned MODE_W        = 2;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned TDATA_W       = 40;
    localparam int unsigned STORE_DEPTH_D = 1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BITS  = 2'd0,
        MODE_PUSH_ALIGN = 2'd1,
        MODE_POP_BITS   = 2'd2,
        MODE_POP_ALIGN  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_DATA = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

endpackage

`default_nettype wire

### design/bgf_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module bgf_ram #(
    parameter int unsigned WIDTH = bgf_pkg::BYTE_W,
    parameter int unsigned DEPTH = bgf_pkg::STORE_DEPTH_D
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/bit_granular_fifo_top.sv
// top level of the bit-granular fifo: bit-serial push and pop over a byte store
//
// channel  dir  handshake          tdata                          tuser
// s_       in   s_tvalid/s_tready  [31:0] value, [37:32] length   [1:0] mode
// m_       out  m_tvalid/m_tready  [31:0] data, [37:32] count     [1:0] status
//
// one transfer at a time; a push shifts its bits into the pending word and flushes each full word to the byte store
// a pop shifts bits out of the outgoing word, refilling that word from the byte store or the pending word
// a pop align discards bits of the outgoing word up to the next byte boundary
// reset is synchronous on aresetn; the byte store needs no clearing pass
// a new transfer is taken while the previous result still waits on m_
`default_nettype none

module bit_granular_fifo_top #(
    parameter int unsigned STORE_DEPTH = bgf_pkg::STORE_DEPTH_D
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [bgf_pkg::TDATA_W-1:0]  s_tdata,   // value, length
    input  wire logic [bgf_pkg::MODE_W-1:0]   s_tuser,   // mode
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [bgf_pkg::TDATA_W-1:0]  m_tdata,   // data, count
    output logic      [bgf_pkg::STATUS_W-1:0] m_tuser    // status
);

    import bgf_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int unsigned IDX_W  = $clog2(WORD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_STORE,
        ST_POP,
        ST_LOAD_REQ,
        ST_LOAD_CAP,
        ST_DROP,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [WORD_W-1:0]   pend_reg, pend_next;
    logic [LEN_W-1:0]    pend_cnt_reg, pend_cnt_next;
    logic [WORD_W-1:0]   out_reg, out_next;
    logic [LEN_W-1:0]    out_cnt_reg, out_cnt_next;
    logic [WORD_W-1:0]   val_reg, val_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]   res_data_reg, res_data_next;
    logic [LEN_W-1:0]    res_count_reg, res_count_next;
    status_t             res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [STATUS_W-1:0] m_user_reg, m_user_next;

    logic [WORD_W-1:0]   in_value;
    logic [LEN_W-1:0]    in_length;
    logic [LEN_W-1:0]    len_sat;
    logic [2:0]          pad;
    logic [LEN_W:0]      push_sum;
    logic [LEN_W:0]      pad_sum;
    logic                store_tight;

    logic                ram_wr_en;
    logic [BYTE_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [BYTE_W-1:0]   ram_rd_data;
    logic [1:0]          load_slot;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(STORE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign in_value    = s_tdata[WORD_W-1:0];
    assign in_length   = s_tdata[WORD_W +: LEN_W];
    assign len_sat     = (in_length > LEN_W'(WORD_W)) ? LEN_W'(WORD_W) : in_length;
    assign pad         = 3'(3'd0 - pend_cnt_reg[2:0]);
    assign push_sum    = {1'b0, pend_cnt_reg} + {1'b0, len_sat};
    assign pad_sum     = {1'b0, pend_cnt_reg} + (LEN_W+1)'(pad);
    assign store_tight = fill_reg > FILL_W'(STORE_DEPTH - 4);
    assign load_slot   = 2'(2'd3 - out_cnt_reg[4:3]);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        pend_next       = pend_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_next        = out_reg;
        out_cnt_next    = out_cnt_reg;
        val_next        = val_reg;
        rem_next        = rem_reg;
        res_data_next   = res_data_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        ram_wr_en       = 1'b0;
        ram_wr_data     = pend_reg[WORD_W-1 -: BYTE_W];
        ram_rd_en       = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_data_next   = '0;
                    res_count_next  = '0;
                    res_status_next = STATUS_OK;
                    val_next        = in_value;
                    rem_next        = '0;
                    state_next      = ST_DONE;
                    unique case (mode_t'(s_tuser))
                        MODE_PUSH_BITS: begin
                            if (len_sat != '0) begin
                                if (push_sum >= (LEN_W+1)'(WORD_W) && store_tight) begin
                                    res_status_next = STATUS_FULL;
                                end else begin
                                    rem_next       = len_sat;
                                    res_count_next = len_sat;
                                    state_next     = ST_PUSH;
                                end
                            end
                        end
                        MODE_PUSH_ALIGN: begin
                            val_next = '0;
                            if (pad != '0) begin
                                if (pad_sum >= (LEN_W+1)'(WORD_W) && store_tight) begin
                                    res_status_next = STATUS_FULL;
                                end else begin
                                    rem_next       = LEN_W'(pad);
                                    res_count_next = LEN_W'(pad);
                                    state_next     = ST_PUSH;
                                end
                            end
                        end
                        MODE_POP_BITS: begin
                            if (len_sat != '0) begin
                                rem_next   = len_sat;
                                state_next = ST_POP;
                            end
                        end
                        MODE_POP_ALIGN: begin
                            state_next = ST_DROP;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PUSH: begin
                if (pend_cnt_reg == LEN_W'(WORD_W)) begin
                    state_next = ST_STORE;
                end else if (rem_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    pend_next[IDX_W'(LEN_W'(WORD_W - 1) - pend_cnt_reg)] =
                        val_reg[IDX_W'(rem_reg - 1'b1)];
                    pend_cnt_next = pend_cnt_reg + 1'b1;
                    rem_next      = rem_reg - 1'b1;
                end
            end

            ST_STORE: begin
                ram_wr_en     = 1'b1;
                tail_next     = ptr_inc(tail_reg);
                fill_next     = fill_reg + 1'b1;
                pend_next     = {pend_reg[WORD_W-BYTE_W-1:0], BYTE_W'(0)};
                pend_cnt_next = pend_cnt_reg - LEN_W'(BYTE_W);
                if (pend_cnt_reg == LEN_W'(BYTE_W)) begin
                    state_next = ST_PUSH;
                end
            end

            ST_POP: begin
                if (rem_reg == '0) begin
                    state_next = ST_DONE;
                end else if (out_cnt_reg != '0) begin
                    res_data_next  = {res_data_reg[WORD_W-2:0], out_reg[WORD_W-1]};
                    out_next       = {out_reg[WORD_W-2:0], 1'b0};
                    out_cnt_next   = out_cnt_reg - 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    res_count_next = res_count_reg + 1'b1;
                end else if (fill_reg != '0) begin
                    state_next = ST_LOAD_REQ;
                end else if (pend_cnt_reg != '0) begin
                    out_next      = pend_reg;
                    out_cnt_next  = pend_cnt_reg;
                    pend_next     = '0;
                    pend_cnt_next = '0;
                end else begin
                    if (res_count_reg == '0) begin
                        res_status_next = STATUS_NO_DATA;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_LOAD_REQ: begin
                ram_rd_en  = 1'b1;
                head_next  = ptr_inc(head_reg);
                fill_next  = fill_reg - 1'b1;
                state_next = ST_LOAD_CAP;
            end

            ST_LOAD_CAP: begin
                out_next[{load_slot, 3'b000} +: BYTE_W] = ram_rd_data;
                out_cnt_next = out_cnt_reg + LEN_W'(BYTE_W);
                if (out_cnt_next < LEN_W'(WORD_W) && fill_reg != '0) begin
                    state_next = ST_LOAD_REQ;
                end else begin
                    state_next = ST_POP;
                end
            end

            ST_DROP: begin
                if (out_cnt_reg[2:0] != '0) begin
                    out_next       = {out_reg[WORD_W-2:0], 1'b0};
                    out_cnt_next   = out_cnt_reg - 1'b1;
                    res_count_next = res_count_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(TDATA_W-WORD_W-LEN_W)'(0), res_count_reg, res_data_reg};
                    m_user_next  = res_status_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            pend_reg     <= '0;
            pend_cnt_reg <= '0;
            out_reg      <= '0;
            out_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            pend_reg     <= pend_next;
            pend_cnt_reg <= pend_cnt_next;
            out_reg      <= out_next;
            out_cnt_reg  <= out_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        val_reg        <= val_next;
        rem_reg        <= rem_next;
        res_data_reg   <= res_data_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    bgf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // store never overfills and never underflows
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= FILL_W'(STORE_DEPTH)) &&
        !(ram_wr_en && fill_reg == FILL_W'(STORE_DEPTH)) &&
        !(ram_rd_en && fill_reg == '0))
        else $error("byte store fill out of range");

    // bit counts stay within one word
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_cnt_reg <= LEN_W'(WORD_W)) && (out_cnt_reg <= LEN_W'(WORD_W)))
        else $error("bit count above word size");

    // a full pending word is always flushed before the next transfer
    a_idle_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pend_cnt_reg < LEN_W'(WORD_W)))
        else $error("full pending word left in idle");

    // word flush moves whole bytes only
    a_store_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STORE) |-> (pend_cnt_reg[2:0] == '0 && pend_cnt_reg != '0))
        else $error("flush of a partial byte");

    // an empty pop reports nothing popped
    a_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg == STATUS_NO_DATA) |->
            (m_data_reg[WORD_W +: LEN_W] == '0 && m_data_reg[WORD_W-1:0] == '0))
        else $error("no-data result with payload");

endmodule

`default_nettype wire
